FILE: rtl/core/wjmc_pkg.sv
// ============================================================================
// wjmc_pkg - shared definitions for the windowed jump cost core
// Default sizes, fixed port field widths and the control bundle that the
// sequencer hands to the shared cost unit.
// ============================================================================
`timescale 1ns / 1ps

package wjmc_pkg;

    // Default sizing of the history rings and datapath
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int COST_BITS_DEF   = 32;

    // Fixed widths of the port fields
    localparam int HEIGHT_PORT_W = 16;
    localparam int COST_PORT_W   = 32;
    localparam int WIN_CFG_W     = 5;

    // Window size after reset
    localparam logic [WIN_CFG_W-1:0] WIN_RESET = 5'd1;

    // Sequencer to cost unit control
    typedef struct packed {
        logic clear;   // start a new minimum search
        logic valid;   // history read data is present this cycle
    } t_cu_ctl;

endpackage

FILE: rtl/core/windowed_jump_min_cost_core.sv
// ============================================================================
// windowed_jump_min_cost_core - least cost to reach each height in a stream
// Each input beat carries one height; a set first_of_sequence starts a new
// sequence. The result beat gives the least total cost to reach that
// position when one jump may go back up to window_size positions and costs
// the absolute height difference; the first position of a sequence costs 0
// and costs saturate. One item is worked at a time: o_stall stays high from
// acceptance until the result is loaded into the output register. Each item
// walks reach history entries, where reach is the smaller of window_size (clamped
// to 1..MAX_WINDOW) and the items already seen in the sequence; an item with no
// history skips the walk. The walk is paced by the single read port of the
// history rings, walked one entry per cycle into a two-stage shared
// cost/compare unit. A result waits in S_DONE only while the output side
// stalls. window_size is written over the cfg channel; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ============================================================================
`timescale 1ns / 1ps

module windowed_jump_min_cost_core #(
    parameter int MAX_WINDOW  = wjmc_pkg::MAX_WINDOW_DEF,
    parameter int HEIGHT_BITS = wjmc_pkg::HEIGHT_BITS_DEF,
    parameter int COST_BITS   = wjmc_pkg::COST_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wjmc_pkg::WIN_CFG_W-1:0]     i_cfg_window_size,
    // Input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [wjmc_pkg::HEIGHT_PORT_W-1:0] i_height,
    input  logic                               i_first_of_sequence,
    // Output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [wjmc_pkg::COST_PORT_W-1:0]   o_min_cost
);

    import wjmc_pkg::*;

    localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int WCMP_W = (CNT_W > WIN_CFG_W) ? CNT_W : WIN_CFG_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_WINDOW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [WIN_CFG_W-1:0]    r_window_size;
    logic [HEIGHT_BITS-1:0]  r_height, n_height;
    logic [CNT_W-1:0]        r_seen, n_seen;
    logic [CNT_W-1:0]        r_items_seen, n_items_seen;
    logic [CNT_W-1:0]        r_left, n_left;
    logic                    r_no_hist, n_no_hist;
    logic [PTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic                    r_rd_vld;
    logic                    r_o_valid, n_o_valid;
    logic [COST_PORT_W-1:0]  r_o_min_cost, n_o_min_cost;

    logic                    in_accept;
    logic                    out_free;
    logic [CNT_W-1:0]        seen_acc;
    logic [WCMP_W-1:0]       win_c;
    logic [CNT_W-1:0]        reach_acc;
    logic                    rd_en;
    logic                    wr_en;
    logic [COST_BITS-1:0]    cost;
    logic [63:0]             cost_ext;
    t_cu_ctl                 cu_ctl;
    logic                    cu_busy;
    logic [COST_BITS-1:0]    cu_min;
    logic [HEIGHT_BITS-1:0]  hist_height;
    logic [COST_BITS-1:0]    hist_cost;

    assign in_accept   = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_o_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_min_cost  = r_o_min_cost;

    // Window bound and reach for the incoming item
    always_comb begin
        seen_acc = i_first_of_sequence ? '0 : r_items_seen;
        win_c    = WCMP_W'(r_window_size);
        if (win_c == '0) begin
            win_c = WCMP_W'(1);
        end
        if (win_c > WCMP_W'(MAX_WINDOW)) begin
            win_c = WCMP_W'(MAX_WINDOW);
        end
        reach_acc = (WCMP_W'(seen_acc) < win_c) ? seen_acc : CNT_W'(win_c);
    end

    // Final cost, widened for its saturation to the port width
    always_comb begin
        cost     = r_no_hist ? '0 : cu_min;
        cost_ext = 64'(cost);
    end

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_height     = r_height;
        n_seen       = r_seen;
        n_items_seen = r_items_seen;
        n_left       = r_left;
        n_no_hist    = r_no_hist;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_o_valid    = r_o_valid && i_stall;
        n_o_min_cost = r_o_min_cost;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_height  = HEIGHT_BITS'(i_height);
                    n_seen    = seen_acc;
                    n_left    = reach_acc;
                    n_no_hist = (reach_acc == '0);
                    n_rd_ptr  = (r_wr_ptr == '0) ? PTR_LAST : r_wr_ptr - 1'b1;
                    n_state   = (reach_acc == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                // one history entry per cycle, newest first
                rd_en    = 1'b1;
                n_rd_ptr = (r_rd_ptr == '0) ? PTR_LAST : r_rd_ptr - 1'b1;
                n_left   = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_rd_vld && !cu_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    wr_en        = 1'b1;
                    n_o_valid    = 1'b1;
                    n_o_min_cost = (cost_ext > 64'hFFFF_FFFF) ? '1 : cost_ext[31:0];
                    n_wr_ptr     = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                    n_items_seen = (r_seen == CNT_MAX) ? CNT_MAX : r_seen + 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= WIN_RESET;
            r_items_seen  <= '0;
            r_wr_ptr      <= '0;
            r_rd_vld      <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_items_seen <= n_items_seen;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_vld     <= rd_en;
            r_o_valid    <= n_o_valid;
            if (i_cfg_valid) begin
                r_window_size <= i_cfg_window_size;
            end
        end
        r_height     <= n_height;
        r_seen       <= n_seen;
        r_left       <= n_left;
        r_no_hist    <= n_no_hist;
        r_rd_ptr     <= n_rd_ptr;
        r_o_min_cost <= n_o_min_cost;
    end

    // Cost unit control
    always_comb begin
        cu_ctl.clear = in_accept;
        cu_ctl.valid = r_rd_vld;
    end

    wjmc_hist #(
        .MAX_WINDOW  (MAX_WINDOW),
        .HEIGHT_BITS (HEIGHT_BITS),
        .COST_BITS   (COST_BITS),
        .PTR_W       (PTR_W)
    ) u_hist (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_wr_ptr),
        .i_wr_height (r_height),
        .i_wr_cost   (cost),
        .i_rd_en     (rd_en),
        .i_rd_addr   (r_rd_ptr),
        .o_rd_height (hist_height),
        .o_rd_cost   (hist_cost)
    );

    wjmc_cost_unit #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .COST_BITS   (COST_BITS)
    ) u_cost_unit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (cu_ctl),
        .i_cur_height  (r_height),
        .i_prev_height (hist_height),
        .i_prev_cost   (hist_cost),
        .o_busy        (cu_busy),
        .o_min         (cu_min)
    );

endmodule

FILE: rtl/core/wjmc_hist.sv
// ============================================================================
// wjmc_hist - height and cost history rings
// One write port and one read port; read data is registered.
// ============================================================================
`timescale 1ns / 1ps

module wjmc_hist #(
    parameter int MAX_WINDOW  = 16,
    parameter int HEIGHT_BITS = 16,
    parameter int COST_BITS   = 32,
    parameter int PTR_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [PTR_W-1:0]       i_wr_addr,
    input  logic [HEIGHT_BITS-1:0] i_wr_height,
    input  logic [COST_BITS-1:0]   i_wr_cost,
    input  logic                   i_rd_en,
    input  logic [PTR_W-1:0]       i_rd_addr,
    output logic [HEIGHT_BITS-1:0] o_rd_height,
    output logic [COST_BITS-1:0]   o_rd_cost
);

    logic [HEIGHT_BITS-1:0] r_height_mem [MAX_WINDOW];
    logic [COST_BITS-1:0]   r_cost_mem   [MAX_WINDOW];
    logic [HEIGHT_BITS-1:0] r_rd_height;
    logic [COST_BITS-1:0]   r_rd_cost;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_height_mem[i_wr_addr] <= i_wr_height;
            r_cost_mem[i_wr_addr]   <= i_wr_cost;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_height <= r_height_mem[i_rd_addr];
            r_rd_cost   <= r_cost_mem[i_rd_addr];
        end
    end

    assign o_rd_height = r_rd_height;
    assign o_rd_cost   = r_rd_cost;

endmodule

FILE: rtl/core/wjmc_cost_unit.sv
// ============================================================================
// wjmc_cost_unit - shared jump cost and running minimum
// Stage A forms |h - h_prev| plus the stored cost with saturation; stage B
// folds the candidate into the running minimum.
// ============================================================================
`timescale 1ns / 1ps

module wjmc_cost_unit #(
    parameter int HEIGHT_BITS = 16,
    parameter int COST_BITS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wjmc_pkg::t_cu_ctl      i_ctl,
    input  logic [HEIGHT_BITS-1:0] i_cur_height,
    input  logic [HEIGHT_BITS-1:0] i_prev_height,
    input  logic [COST_BITS-1:0]   i_prev_cost,
    output logic                   o_busy,
    output logic [COST_BITS-1:0]   o_min
);

    import wjmc_pkg::*;

    localparam int SUM_W = ((COST_BITS > HEIGHT_BITS) ? COST_BITS : HEIGHT_BITS) + 1;

    logic [HEIGHT_BITS-1:0] diff;
    logic [SUM_W-1:0]       sum;
    logic [COST_BITS-1:0]   cand;
    logic                   r_cand_vld;
    logic [COST_BITS-1:0]   r_cand;
    logic [COST_BITS-1:0]   r_min;

    // Stage A: absolute height difference plus saturating add
    always_comb begin
        diff = (i_cur_height >= i_prev_height) ? (i_cur_height - i_prev_height)
                                               : (i_prev_height - i_cur_height);
        sum  = SUM_W'(i_prev_cost) + SUM_W'(diff);
        cand = (sum[SUM_W-1:COST_BITS] != '0) ? '1 : sum[COST_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
        end else begin
            r_cand_vld <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= cand;
    end

    // Stage B: running minimum, preset to the top of the range
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_min <= '1;
        end else if (r_cand_vld && (r_cand < r_min)) begin
            r_min <= r_cand;
        end
    end

    assign o_busy = r_cand_vld;
    assign o_min  = r_min;

endmodule

FILE: sim/tb_windowed_jump_min_cost_core.sv
// ============================================================================
// tb_windowed_jump_min_cost_core - self-checking bench for the jump cost core
// Streams heights through the core under several window settings. It checks
// every result beat against a local minimum cost predictor that tracks the
// height and cost rings and the sequence count. Directed beats cover the
// height extremes, the missing start flag after reset and the window clamps.
// Random sequences then run under three idle patterns on both sides.
// ============================================================================
`timescale 1ns / 1ps

module tb_windowed_jump_min_cost_core;

    import wjmc_pkg::*;

    localparam int RING_DEPTH  = MAX_WINDOW_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_COUNT   = 12;
    localparam int SEG_ITEMS   = 134;

    typedef struct {
        logic [HEIGHT_PORT_W-1:0] height;
        logic                     first;
    } t_height_beat;

    // Shapes of random height runs
    typedef enum logic [1:0] {
        HT_FULL,   // any 16-bit value
        HT_NEAR,   // close to a base, many ties
        HT_RAIL,   // only 0 and all ones
        HT_LOW     // small values
    } t_height_pattern;

    // DUT signals
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [WIN_CFG_W-1:0]     i_cfg_window_size = '0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [HEIGHT_PORT_W-1:0] i_height = '0;
    logic                     i_first_of_sequence = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [COST_PORT_W-1:0]   o_min_cost;

    // Bench state
    t_height_beat           pending_beats[$];
    logic [COST_PORT_W-1:0] expected_costs[$];
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     mismatch_count = 0;
    int                     cycle_count = 0;

    // Predictor state
    logic [HEIGHT_PORT_W-1:0] ring_height[RING_DEPTH];
    logic [COST_PORT_W-1:0]   ring_cost[RING_DEPTH];
    logic [3:0]               ring_ptr = '0;
    int                       seq_count = 0;
    logic [WIN_CFG_W-1:0]     win_setting = WIN_RESET;

    windowed_jump_min_cost_core u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_size   (i_cfg_window_size),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_height            (i_height),
        .i_first_of_sequence (i_first_of_sequence),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_min_cost          (o_min_cost)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Least cost for one height; advances the rings and the sequence count
    function automatic logic [COST_PORT_W-1:0] predict_min_cost(
        input logic [HEIGHT_PORT_W-1:0] h,
        input logic                     first
    );
        int                       span;
        int                       reach;
        int                       j;
        logic [3:0]               idx;
        logic [HEIGHT_PORT_W-1:0] ph;
        logic [HEIGHT_PORT_W-1:0] diff;
        logic [COST_PORT_W:0]     cand;
        logic [COST_PORT_W-1:0]   best;
        if (first) seq_count = 0;
        span = win_setting;
        if (span == 0) span = 1;
        if (span > RING_DEPTH) span = RING_DEPTH;
        reach = (seq_count < span) ? seq_count : span;
        if (reach == 0) begin
            best = '0;
        end else begin
            best = '1;
            for (j = 1; j <= reach; j++) begin
                idx  = ring_ptr - 4'(j);
                ph   = ring_height[idx];
                diff = (h >= ph) ? h - ph : ph - h;
                cand = {1'b0, ring_cost[idx]} + {17'b0, diff};
                // saturate at the top of the cost range
                if (cand[COST_PORT_W]) cand = {1'b0, {COST_PORT_W{1'b1}}};
                if (cand[COST_PORT_W-1:0] < best) best = cand[COST_PORT_W-1:0];
            end
        end
        ring_height[ring_ptr] = h;
        ring_cost[ring_ptr]   = best;
        ring_ptr              = ring_ptr + 4'd1;
        if (seq_count < RING_DEPTH) seq_count++;
        return best;
    endfunction

    // Input driver: predicts on each accepted beat, then loads the next one
    always @(posedge i_clk) begin
        t_height_beat b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_costs.push_back(predict_min_cost(i_height, i_first_of_sequence));
            if (!i_valid || !o_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    b = pending_beats.pop_front();
                    i_valid             <= 1'b1;
                    i_height            <= b.height;
                    i_first_of_sequence <= b.first;
                end else begin
                    i_valid             <= 1'b0;
                    i_height            <= 16'($urandom);
                    i_first_of_sequence <= 1'($urandom);
                end
            end
        end
    end

    // Output monitor and receiver stall
    always @(posedge i_clk) begin
        logic [COST_PORT_W-1:0] exp_cost;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_costs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result beat with none expected, min_cost=%0d",
                                 o_min_cost);
                end else begin
                    exp_cost = expected_costs.pop_front();
                    if (o_min_cost !== exp_cost) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("ERROR: min_cost expected %0d, got %0d",
                                     exp_cost, o_min_cost);
                    end
                end
            end
            i_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_beat(input logic [HEIGHT_PORT_W-1:0] h, input logic first);
        t_height_beat b;
        b.height = h;
        b.first  = first;
        pending_beats.push_back(b);
    endtask

    // Hold the sender until every expected beat is back, then let the core settle
    task automatic wait_for_drain();
        while (pending_beats.size() != 0 || i_valid || expected_costs.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_window_size <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid       <= 1'b0;
        i_cfg_window_size <= 5'($urandom);
        win_setting = value;
    endtask

    // Random sequences: mostly led by a start flag, with stray flags as noise
    task automatic push_random_items(input int count);
        int              left;
        int              seq_len;
        int              k;
        t_height_pattern pattern;
        logic [15:0]     base;
        logic [15:0]     h;
        logic            first;
        left = count;
        while (left > 0) begin
            seq_len = $urandom_range(40, 1);
            pattern = t_height_pattern'($urandom_range(3, 0));
            base    = 16'($urandom);
            for (k = 0; k < seq_len && left > 0; k++) begin
                first = (k == 0) ? ($urandom_range(9, 0) != 0) : ($urandom_range(49, 0) == 0);
                case (pattern)
                    HT_FULL: h = 16'($urandom);
                    HT_NEAR: h = base + 16'($urandom_range(15, 0));
                    HT_RAIL: h = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
                    default: h = 16'($urandom_range(255, 0));
                endcase
                push_beat(h, first);
                left--;
            end
        end
    endtask

    initial begin
        logic [WIN_CFG_W-1:0] seg_win[SEG_COUNT];
        int                   seg;
        int                   half;
        logic [WIN_CFG_W-1:0] w;
        seg_win = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd16, 5'd3, 5'd12, 5'd17,
                    5'd16, 5'd5, 5'd2, 5'd31};
        foreach (ring_height[i]) begin
            ring_height[i] = '0;
            ring_cost[i]   = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of one; first beats carry no start flag
        push_beat(16'd1234, 1'b0);
        push_beat(16'h0000, 1'b0);
        push_beat(16'hFFFF, 1'b0);
        push_beat(16'h0000, 1'b1);
        push_beat(16'hFFFF, 1'b0);
        wait_for_drain();

        // Full window: ring wraps and the count saturates
        write_window(5'd16);
        push_beat(16'h0000, 1'b1);
        for (int i = 0; i < 15; i++)
            push_beat((i % 3 == 0) ? 16'hFFFF : 16'(i * 4099), 1'b0);
        wait_for_drain();

        // Window zero acts as one; oversized window clamps to the ring depth
        write_window(5'd0);
        push_beat(16'h8000, 1'b1);
        push_beat(16'h7FFF, 1'b0);
        wait_for_drain();
        write_window(5'd31);
        push_beat(16'hFFFF, 1'b1);
        push_beat(16'h0001, 1'b0);
        wait_for_drain();

        // Random segments under three idle patterns
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg / 4)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            w = (seg % 4 == 1) ? 5'($urandom_range(15, 2)) : seg_win[seg];
            write_window(w);
            half = $urandom_range(SEG_ITEMS - 10, 10);
            push_random_items(half);
            // sender holds until the core has returned everything
            wait_for_drain();
            push_random_items(SEG_ITEMS - half);
            wait_for_drain();
        end

        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && expected_costs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: windowed_jump_min_cost_core.f
rtl/core/wjmc_pkg.sv
rtl/core/wjmc_hist.sv
rtl/core/wjmc_cost_unit.sv
rtl/core/windowed_jump_min_cost_core.sv
sim/tb_windowed_jump_min_cost_core.sv
